// ----- src/qea_pkg.sv -----
// Shared types and constants for the quadrature encoder with acceleration.
// No dependencies; imported by quadrature_encoder_with_accel.
`default_nettype none

package qea_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_DETENT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_FACTOR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_COEF    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INCREMENT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_MIN     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_VALUE_MAX     = 3'd6;

    // action codes
    localparam logic [1:0] ACT_SAMPLE = 2'd0;
    localparam logic [1:0] ACT_READ   = 2'd1;
    localparam logic [1:0] ACT_LOAD   = 2'd2;

    // register reset values
    localparam logic [7:0]  STEPS_DETENT_RST = 8'd4;
    localparam logic [7:0]  STEP_FACTOR_RST  = 8'd1;
    localparam logic [31:0] INCREMENT_RST    = 32'(64'd1 << FRACTION_BITS);
    localparam logic [31:0] VALUE_MAX_RST    = 32'(64'd100 << FRACTION_BITS);

    // acceleration timing
    localparam logic [31:0] ACCEL_WINDOW_MS = 32'd200;
    localparam logic [31:0] ACCEL_MIN_MS    = 32'd4;

    // read product saturates at 2^40; sum of value and product fits SUM_W
    localparam int PROD_W = 42;
    localparam int SUM_W  = 43;
    localparam logic [PROD_W-1:0] PROD_SAT = PROD_W'(64'd1 << 40);

    typedef enum logic [1:0] {
        LIM_NORMAL = 2'd0,
        LIM_MAX    = 2'd1,
        LIM_MIN    = 2'd2
    } lim_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_DET_A,
        ST_DET_B,
        ST_ACCEL,
        ST_RD_DIV,
        ST_MUL,
        ST_SUM,
        ST_CLAMP,
        ST_CHK_GO,
        ST_CHK,
        ST_DONE
    } st_t;

    typedef struct packed {
        logic [1:0]         action;
        logic               pin_a;
        logic               pin_b;
        logic [31:0]        now_ms;
        logic signed [31:0] load_value;
    } item_t;

    typedef struct packed {
        logic signed [31:0] value_out;
        logic signed [31:0] count_out;
        logic               changed;
        logic [1:0]         limit_state;
    } result_t;

    // quadrature transition table, index is {prev A, prev B, A, B}
    function automatic dir_t quad_dir(input logic [3:0] hist);
        dir_t d;
        unique case (hist)
            4'h2, 4'h4, 4'hb, 4'hd: d = DIR_UP;
            4'h1, 4'h7, 4'h8, 4'he: d = DIR_DOWN;
            default:                d = DIR_NONE;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- src/quadrature_encoder_with_accel.sv -----
// Loads finish without the divider; reads and pin samples run on the shared restoring
// divider, one quotient bit per cycle, which is reused for the bit-serial multiply, and
// a pin sample can run an extra division for an acceleration jump.
// One item in flight: next transfer in the cycle after the result loads, later if stalled.
// Reset (rst_n low, async): counters, value, limit flag and history clear,
// registers take their defaults; no clearing pass.
// Top level of the quadrature encoder decoder; uses qea_pkg.
`default_nettype none

module quadrature_encoder_with_accel #(
    parameter int COUNT_BITS = 32
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write,
    input  wire logic [qea_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [qea_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                         item_valid,
    output logic                              item_stall,
    input  wire qea_pkg::item_t               item,
    output logic                              result_valid,
    input  wire logic                         result_stall,
    output qea_pkg::result_t                  result
);
    import qea_pkg::*;

    localparam int CNT_W = $clog2(COUNT_BITS + 1);

    // configuration
    logic               enable_reg, enable_next;
    logic [7:0]         spd_reg, spd_next;
    logic [7:0]         sf_reg, sf_next;
    logic [15:0]        coef_reg, coef_next;
    logic signed [31:0] increment_reg, increment_next;
    logic signed [31:0] value_min_reg, value_min_next;
    logic signed [31:0] value_max_reg, value_max_next;

    // decoder state
    st_t                   state_reg, state_next;
    logic [3:0]            prev_code_reg, prev_code_next;
    logic [COUNT_BITS-1:0] enc_count_reg, enc_count_next;
    logic [COUNT_BITS-1:0] last_read_reg, last_read_next;
    logic signed [31:0]    value_acc_reg, value_acc_next;
    lim_t                  limit_reg, limit_next;
    dir_t                  last_dir_reg, last_dir_next;
    logic [31:0]           last_move_reg, last_move_next;
    logic                  result_valid_reg, result_valid_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;

    // working registers
    item_t                   item_reg, item_next;
    result_t                 result_reg, result_next;
    logic [COUNT_BITS-1:0]   num_reg, num_next;
    logic [7:0]              rem_reg, rem_next;
    logic [7:0]              den_reg, den_next;
    logic [PROD_W-1:0]       acc_reg, acc_next;
    logic                    sat_reg, sat_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [COUNT_BITS-1:0]   qa_reg, qa_next;
    logic [COUNT_BITS-1:0]   old_count_reg, old_count_next;
    logic                    up_reg, up_next;
    logic                    neg_reg, neg_next;
    logic                    changed_reg, changed_next;

    // shared unit controls and helpers
    logic                    div_start;
    logic [COUNT_BITS-1:0]   div_a;
    logic [7:0]              div_b;
    logic                    mul_start;
    logic [8:0]              div_trial;
    logic                    div_ge;
    logic [8:0]              div_diff;
    logic [PROD_W-1:0]       acc_step;
    logic [31:0]             inc_mag;
    logic [PROD_W-1:0]       prod_mag;
    logic signed [SUM_W-1:0] prod_s, val_s, vmax_s, vmin_s;
    logic [COUNT_BITS-1:0]   delta;
    logic [7:0]              det_div, sf_div, el_div;
    logic [31:0]             elapsed;
    logic [3:0]              hist;
    dir_t                    step_dir, want;
    logic                    held, same, div_ready;

    function automatic logic [COUNT_BITS-1:0] mag_of(input logic [COUNT_BITS-1:0] v);
        return v[COUNT_BITS-1] ? (~v + 1'b1) : v;
    endfunction

    assign item_stall   = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign delta     = enc_count_reg - last_read_reg;
    assign det_div   = (spd_reg == 8'd0) ? 8'd1 : spd_reg;
    assign sf_div    = (sf_reg == 8'd0) ? 8'd1 : sf_reg;
    assign elapsed   = item_reg.now_ms - last_move_reg;
    assign el_div    = (elapsed < ACCEL_MIN_MS) ? ACCEL_MIN_MS[7:0] : elapsed[7:0];
    assign hist      = {prev_code_reg[1:0], item_reg.pin_a, item_reg.pin_b};
    assign step_dir  = quad_dir(hist);
    assign want      = up_reg ? DIR_UP : DIR_DOWN;
    assign held      = (limit_reg == LIM_MAX && step_dir == DIR_UP) ||
                       (limit_reg == LIM_MIN && step_dir == DIR_DOWN);
    assign same      = (qa_reg == '0 && num_reg == '0) ||
                       (qa_reg == num_reg &&
                        old_count_reg[COUNT_BITS-1] == enc_count_reg[COUNT_BITS-1]);
    // nonzero whole multiple: quotient nonzero and no remainder
    assign div_ready = (num_reg != '0) && (rem_reg == 8'd0);

    // restoring divider step
    assign div_trial = {rem_reg, num_reg[COUNT_BITS-1]};
    assign div_ge    = (div_trial >= {1'b0, den_reg});
    assign div_diff  = div_trial - {1'b0, den_reg};

    // Horner multiply over quotient bits, sticky saturation
    assign inc_mag  = increment_reg[31] ? (~increment_reg + 1'b1) : increment_reg;
    assign acc_step = {acc_reg[PROD_W-2:0], 1'b0} +
                      (num_reg[COUNT_BITS-1] ? PROD_W'(inc_mag) : '0);
    assign prod_mag = sat_reg ? PROD_SAT : acc_reg;
    assign prod_s   = $signed({1'b0, prod_mag});
    assign val_s    = SUM_W'(value_acc_reg);
    assign vmax_s   = SUM_W'(value_max_reg);
    assign vmin_s   = SUM_W'(value_min_reg);

    always_comb
    begin
        enable_next       = enable_reg;
        spd_next          = spd_reg;
        sf_next           = sf_reg;
        coef_next         = coef_reg;
        increment_next    = increment_reg;
        value_min_next    = value_min_reg;
        value_max_next    = value_max_reg;
        state_next        = state_reg;
        prev_code_next    = prev_code_reg;
        enc_count_next    = enc_count_reg;
        last_read_next    = last_read_reg;
        value_acc_next    = value_acc_reg;
        limit_next        = limit_reg;
        last_dir_next     = last_dir_reg;
        last_move_next    = last_move_reg;
        result_valid_next = result_valid_reg;
        cnt_next          = cnt_reg;
        item_next         = item_reg;
        result_next       = result_reg;
        num_next          = num_reg;
        rem_next          = rem_reg;
        den_next          = den_reg;
        acc_next          = acc_reg;
        sat_next          = sat_reg;
        sum_next          = sum_reg;
        qa_next           = qa_reg;
        old_count_next    = old_count_reg;
        up_next           = up_reg;
        neg_next          = neg_reg;
        changed_next      = changed_reg;
        div_start         = 1'b0;
        div_a             = '0;
        div_b             = 8'd1;
        mul_start         = 1'b0;

        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ENABLE:       enable_next    = cfg_data[0];
                REG_STEPS_DETENT: spd_next       = cfg_data[7:0];
                REG_STEP_FACTOR:  sf_next        = cfg_data[7:0];
                REG_ACCEL_COEF:   coef_next      = cfg_data[15:0];
                REG_INCREMENT:    increment_next = $signed(cfg_data);
                REG_VALUE_MIN:    value_min_next = $signed(cfg_data);
                REG_VALUE_MAX:    value_max_next = $signed(cfg_data);
                default:
                begin
                end
            endcase
        end

        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_next  = item;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                priority if (item_reg.action == ACT_SAMPLE && enable_reg)
                begin
                    prev_code_next = hist;
                    if (step_dir == DIR_NONE)
                    begin
                        last_dir_next = DIR_NONE;
                        state_next    = ST_CHK_GO;
                    end
                    else
                    begin
                        up_next        = (step_dir == DIR_UP);
                        old_count_next = enc_count_reg;
                        if (!held)
                        begin
                            enc_count_next = (step_dir == DIR_UP) ? enc_count_reg + 1'b1
                                                                  : enc_count_reg - 1'b1;
                        end
                        div_start  = 1'b1;
                        div_a      = mag_of(enc_count_reg);
                        div_b      = det_div;
                        state_next = ST_DET_A;
                    end
                end
                else if (item_reg.action == ACT_READ)
                begin
                    neg_next   = delta[COUNT_BITS-1];
                    div_start  = 1'b1;
                    div_a      = mag_of(delta);
                    div_b      = sf_div;
                    state_next = ST_RD_DIV;
                end
                else if (item_reg.action == ACT_LOAD)
                begin
                    last_read_next = enc_count_reg;
                    value_acc_next = item_reg.load_value;
                    changed_next   = 1'b0;
                    state_next     = ST_DONE;
                end
                else
                begin
                    // unused action or sample while disabled: report only
                    state_next = ST_CHK_GO;
                end
            end
            ST_DET_A:
            begin
                if (cnt_reg == '0)
                begin
                    qa_next    = num_reg;
                    div_start  = 1'b1;
                    div_a      = mag_of(enc_count_reg);
                    div_b      = det_div;
                    state_next = ST_DET_B;
                end
            end
            ST_DET_B:
            begin
                if (cnt_reg == '0)
                begin
                    if (!same && coef_reg > 16'd1 && last_dir_reg == want &&
                        elapsed < ACCEL_WINDOW_MS)
                    begin
                        div_start  = 1'b1;
                        div_a      = COUNT_BITS'(coef_reg);
                        div_b      = el_div;
                        state_next = ST_ACCEL;
                    end
                    else
                    begin
                        last_move_next = item_reg.now_ms;
                        last_dir_next  = want;
                        state_next     = ST_CHK_GO;
                    end
                end
            end
            ST_ACCEL:
            begin
                if (cnt_reg == '0)
                begin
                    // jump is not limit checked
                    enc_count_next = up_reg ? enc_count_reg + num_reg
                                            : enc_count_reg - num_reg;
                    last_move_next = item_reg.now_ms;
                    last_dir_next  = want;
                    state_next     = ST_CHK_GO;
                end
            end
            ST_RD_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    if (div_ready)
                    begin
                        last_read_next = enc_count_reg;
                        mul_start      = 1'b1;
                        state_next     = ST_MUL;
                    end
                    else
                    begin
                        changed_next = 1'b0;
                        state_next   = ST_DONE;
                    end
                end
            end
            ST_MUL:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                sum_next   = (neg_reg ^ increment_reg[31]) ? val_s - prod_s : val_s + prod_s;
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                // max check wins on a swapped range
                priority if (sum_reg >= vmax_s)
                begin
                    value_acc_next = value_max_reg;
                    limit_next     = LIM_MAX;
                end
                else if (sum_reg <= vmin_s)
                begin
                    value_acc_next = value_min_reg;
                    limit_next     = LIM_MIN;
                end
                else
                begin
                    value_acc_next = $signed(sum_reg[31:0]);
                    limit_next     = LIM_NORMAL;
                end
                changed_next = 1'b0;
                state_next   = ST_DONE;
            end
            ST_CHK_GO:
            begin
                div_start  = 1'b1;
                div_a      = mag_of(delta);
                div_b      = sf_div;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (cnt_reg == '0)
                begin
                    changed_next = div_ready;
                    state_next   = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_next.value_out   = value_acc_reg;
                    result_next.count_out   = 32'(enc_count_reg);
                    result_next.changed     = changed_reg;
                    result_next.limit_state = limit_reg;
                    result_valid_next       = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // shared divider / multiplier datapath
        priority if (div_start)
        begin
            num_next = div_a;
            rem_next = 8'd0;
            den_next = div_b;
            cnt_next = CNT_W'(COUNT_BITS);
        end
        else if (mul_start)
        begin
            acc_next = '0;
            sat_next = 1'b0;
            cnt_next = CNT_W'(COUNT_BITS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (state_reg == ST_MUL)
            begin
                num_next = {num_reg[COUNT_BITS-2:0], 1'b0};
                if (!sat_reg)
                begin
                    acc_next = acc_step;
                    sat_next = (acc_step > PROD_SAT);
                end
            end
            else
            begin
                num_next = {num_reg[COUNT_BITS-2:0], div_ge};
                rem_next = div_ge ? div_diff[7:0] : div_trial[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg       <= 1'b0;
            spd_reg          <= STEPS_DETENT_RST;
            sf_reg           <= STEP_FACTOR_RST;
            coef_reg         <= 16'd0;
            increment_reg    <= $signed(INCREMENT_RST);
            value_min_reg    <= 32'sd0;
            value_max_reg    <= $signed(VALUE_MAX_RST);
            state_reg        <= ST_IDLE;
            prev_code_reg    <= 4'd0;
            enc_count_reg    <= '0;
            last_read_reg    <= '0;
            value_acc_reg    <= 32'sd0;
            limit_reg        <= LIM_NORMAL;
            last_dir_reg     <= DIR_NONE;
            last_move_reg    <= 32'd0;
            result_valid_reg <= 1'b0;
            cnt_reg          <= '0;
        end
        else
        begin
            enable_reg       <= enable_next;
            spd_reg          <= spd_next;
            sf_reg           <= sf_next;
            coef_reg         <= coef_next;
            increment_reg    <= increment_next;
            value_min_reg    <= value_min_next;
            value_max_reg    <= value_max_next;
            state_reg        <= state_next;
            prev_code_reg    <= prev_code_next;
            enc_count_reg    <= enc_count_next;
            last_read_reg    <= last_read_next;
            value_acc_reg    <= value_acc_next;
            limit_reg        <= limit_next;
            last_dir_reg     <= last_dir_next;
            last_move_reg    <= last_move_next;
            result_valid_reg <= result_valid_next;
            cnt_reg          <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        result_reg    <= result_next;
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        den_reg       <= den_next;
        acc_reg       <= acc_next;
        sat_reg       <= sat_next;
        sum_reg       <= sum_next;
        qa_reg        <= qa_next;
        old_count_reg <= old_count_next;
        up_reg        <= up_next;
        neg_reg       <= neg_next;
        changed_reg   <= changed_next;
    end

    // a new result only comes out of the final state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result loaded outside ST_DONE");

    // read and load always report the changed flag clear
    a_read_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE &&
         (item_reg.action == ACT_READ || item_reg.action == ACT_LOAD)) |-> !changed_reg)
        else $error("changed set after read or load");

    // the count only moves on a step or an acceleration jump
    a_count_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (enc_count_reg != $past(enc_count_reg)) |->
            $past(state_reg == ST_START || state_reg == ST_ACCEL))
        else $error("count changed outside step or jump");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(COUNT_BITS))
        else $error("iteration counter out of range");

endmodule

`default_nettype wire

// ----- tb/sv/tb_quadrature_encoder_with_accel.sv -----
// Self-checking testbench for quadrature_encoder_with_accel: directed and random
// pin samples, reads and loads, each result checked against an in-bench encoder model.
// Depends on qea_pkg and the quadrature_encoder_with_accel RTL.
`timescale 1ns / 100ps

module tb_quadrature_encoder_with_accel;

    import qea_pkg::*;

    localparam logic [1:0]           ACT_NONE    = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;
    localparam logic [31:0]          ACCEL_SPAN  = 32'd200;
    localparam logic [31:0]          MIN_ELAPSED = 32'd4;
    localparam longint               PROD_LIMIT  = longint'(1) << 40;
    localparam int                   HOLD_CYCLES = 400;
    localparam int                   DRAIN_CYCLES = 150;
    localparam int                   TIMEOUT_NS  = 5_000_000;
    localparam int                   PHASE_ITEMS = 190;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  item_valid = 1'b0;
    logic                  item_stall;
    item_t                 item = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result;

    // encoder model: configuration
    logic        cfg_en = 1'b0;
    logic [7:0]  cfg_detent = 8'd4;
    logic [7:0]  cfg_sfac = 8'd1;
    logic [15:0] cfg_coef = 16'd0;
    logic [31:0] cfg_incr = 32'h0001_0000;
    logic [31:0] cfg_min = 32'd0;
    logic [31:0] cfg_max = 32'd100 << 16;

    // encoder model: state
    logic [3:0]  hist = 4'd0;
    logic [31:0] enc_cnt = 32'd0;
    logic [31:0] read_mark = 32'd0;
    logic [31:0] acc = 32'd0;
    logic [31:0] move_ms = 32'd0;
    lim_t        lim = LIM_NORMAL;
    dir_t        last_dir = DIR_NONE;

    item_t       actions_q[$];
    result_t     readouts_due[$];
    result_t     want_r;
    int          queued_total = 0;
    int          mismatches = 0;
    bit          item_taken = 1'b0;
    bit          quiet = 1'b0;
    bit          hold_go = 1'b0;
    bit          hold_on = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    logic [31:0] clock_ms = 32'd0;
    logic [1:0]  wheel_pos = 2'd0;

    quadrature_encoder_with_accel u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #4 clk = ~clk;

    function automatic int quad_step(input logic [3:0] h);
        case (h)
            4'd2, 4'd4, 4'd11, 4'd13: return 1;
            4'd1, 4'd7, 4'd8, 4'd14:  return -1;
            default:                  return 0;
        endcase
    endfunction

    function automatic logic [31:0] mag32(input logic [31:0] v);
        return v[31] ? -v : v;
    endfunction

    // zero divisor register acts as one
    function automatic logic [31:0] divisor_of(input logic [7:0] r);
        return (r == 8'd0) ? 32'd1 : {24'd0, r};
    endfunction

    function automatic bit same_detent(input logic [31:0] a, input logic [31:0] b,
                                       input logic [31:0] d);
        logic [31:0] qa;
        logic [31:0] qb;
        qa = mag32(a) / d;
        qb = mag32(b) / d;
        if (qa == 0 && qb == 0)
            return 1'b1;
        return qa == qb && a[31] == b[31];
    endfunction

    function automatic bit unread_ready();
        logic [31:0] m;
        m = mag32(enc_cnt - read_mark);
        return m != 0 && (m % divisor_of(cfg_sfac)) == 0;
    endfunction

    function automatic result_t advance_encoder(input item_t it);
        result_t     r;
        int          stp;
        logic [31:0] old;
        logic [31:0] el;
        logic [31:0] amt;
        logic [31:0] dl;
        logic [31:0] quot;
        dir_t        want;
        bit          held;
        longint      qq;
        longint      inc;
        longint      mag_inc;
        longint      prod;
        longint      total;
        longint      hi;
        longint      lo;
        case (it.action)
            ACT_SAMPLE:
                if (cfg_en)
                begin
                    hist = {hist[1:0], it.pin_a, it.pin_b};
                    stp = quad_step(hist);
                    if (stp != 0)
                    begin
                        old = enc_cnt;
                        want = (stp > 0) ? DIR_UP : DIR_DOWN;
                        held = (lim == LIM_MAX && stp > 0) || (lim == LIM_MIN && stp < 0);
                        if (!held)
                            enc_cnt = (stp > 0) ? enc_cnt + 32'd1 : enc_cnt - 32'd1;
                        // detent crossed while spinning the same way: jump ahead
                        if (!same_detent(old, enc_cnt, divisor_of(cfg_detent))
                            && cfg_coef > 16'd1 && last_dir == want)
                        begin
                            el = it.now_ms - move_ms;
                            if (el < ACCEL_SPAN)
                            begin
                                if (el < MIN_ELAPSED)
                                    el = MIN_ELAPSED;
                                amt = {16'd0, cfg_coef} / el;
                                enc_cnt = (stp > 0) ? enc_cnt + amt : enc_cnt - amt;
                            end
                        end
                        move_ms = it.now_ms;
                        last_dir = want;
                    end
                    else
                        last_dir = DIR_NONE;
                end
            ACT_READ:
                if (unread_ready())
                begin
                    dl = enc_cnt - read_mark;
                    read_mark = enc_cnt;
                    quot = mag32(dl) / divisor_of(cfg_sfac);
                    qq = longint'(quot);
                    inc = longint'($signed(cfg_incr));
                    mag_inc = (inc < 0) ? -inc : inc;
                    if (mag_inc != 0 && qq > PROD_LIMIT / mag_inc)
                        prod = PROD_LIMIT;
                    else
                        prod = qq * mag_inc;
                    if (dl[31] != (inc < 0))
                        prod = -prod;
                    total = longint'($signed(acc));
                    total = total + prod;
                    hi = longint'($signed(cfg_max));
                    lo = longint'($signed(cfg_min));
                    // max check first, so it wins on a swapped range
                    if (total >= hi)
                    begin
                        total = hi;
                        lim = LIM_MAX;
                    end
                    else if (total <= lo)
                    begin
                        total = lo;
                        lim = LIM_MIN;
                    end
                    else
                        lim = LIM_NORMAL;
                    acc = total[31:0];
                end
            ACT_LOAD:
            begin
                read_mark = enc_cnt;
                acc = it.load_value;
            end
            default: ;
        endcase
        r.value_out = acc;
        r.count_out = enc_cnt;
        r.changed = unread_ready();
        r.limit_state = lim;
        return r;
    endfunction

    function automatic logic [1:0] gray_code(input logic [1:0] p);
        case (p)
            2'd0:    return 2'b00;
            2'd1:    return 2'b10;
            2'd2:    return 2'b11;
            default: return 2'b01;
        endcase
    endfunction

    // sender: a stalled transfer keeps its payload
    always @(negedge clk)
    begin
        if (!item_valid || item_taken)
        begin
            item_taken = 1'b0;
            if (gap_left > 0)
            begin
                gap_left--;
                item_valid <= 1'b0;
            end
            else if (actions_q.size() == 0)
                item_valid <= 1'b0;
            else if (!quiet && $urandom_range(0, 99) < 20)
            begin
                gap_left = $urandom_range(0, 3);
                item_valid <= 1'b0;
            end
            else
            begin
                item_valid <= 1'b1;
                item <= actions_q[0];
            end
        end
    end

    // receiver stall
    always @(negedge clk)
    begin
        if (hold_on)
            result_stall <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            result_stall <= 1'b1;
        end
        else if (!quiet && $urandom_range(0, 99) < 20)
        begin
            stall_left = $urandom_range(0, 3);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    // long receiver hold-off so the block backs up into its input
    initial
    begin
        wait (hold_go);
        @(posedge clk);
        hold_on = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on = 1'b0;
    end

    // monitor: both channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                readouts_due.push_back(advance_encoder(item));
                void'(actions_q.pop_front());
                item_taken = 1'b1;
            end
            if (result_valid && !result_stall)
            begin
                if (readouts_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected transfer, value %h count %h", $realtime,
                                 result.value_out, result.count_out);
                end
                else
                begin
                    want_r = readouts_due.pop_front();
                    if (result.value_out !== want_r.value_out
                        || result.count_out !== want_r.count_out
                        || result.changed !== want_r.changed
                        || result.limit_state !== want_r.limit_state)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: exp value %h count %h chg %b lim %0d / got %h %h %b %0d",
                                     $realtime, want_r.value_out, want_r.count_out,
                                     want_r.changed, want_r.limit_state, result.value_out,
                                     result.count_out, result.changed, result.limit_state);
                    end
                end
            end
        end
    end

    task automatic push_action(input logic [1:0] act, input logic [1:0] pins,
                               input logic [31:0] ms, input logic [31:0] ld);
        item_t it;
        it.action = act;
        {it.pin_a, it.pin_b} = pins;
        it.now_ms = ms;
        it.load_value = ld;
        actions_q.push_back(it);
        queued_total++;
    endtask

    // unused upper bits of narrow registers carry junk
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        logic [31:0] keep;
        case (idx)
            REG_ENABLE:       keep = 32'h0000_0001;
            REG_STEPS_DETENT,
            REG_STEP_FACTOR:  keep = 32'h0000_00FF;
            REG_ACCEL_COEF:   keep = 32'h0000_FFFF;
            REG_UNUSED:       keep = 32'h0000_0000;
            default:          keep = 32'hFFFF_FFFF;
        endcase
        val = (val & keep) | ($urandom & ~keep);
        case (idx)
            REG_ENABLE:       cfg_en = val[0];
            REG_STEPS_DETENT: cfg_detent = val[7:0];
            REG_STEP_FACTOR:  cfg_sfac = val[7:0];
            REG_ACCEL_COEF:   cfg_coef = val[15:0];
            REG_INCREMENT:    cfg_incr = val;
            REG_VALUE_MIN:    cfg_min = val;
            REG_VALUE_MAX:    cfg_max = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic configure(input logic [7:0] detent, input logic [7:0] sfac,
                             input logic [15:0] coef, input logic [31:0] incr,
                             input logic [31:0] vmin, input logic [31:0] vmax);
        write_reg(REG_ENABLE, 32'd1);
        write_reg(REG_STEPS_DETENT, 32'(detent));
        write_reg(REG_STEP_FACTOR, 32'(sfac));
        write_reg(REG_ACCEL_COEF, 32'(coef));
        write_reg(REG_INCREMENT, incr);
        write_reg(REG_VALUE_MIN, vmin);
        write_reg(REG_VALUE_MAX, vmax);
    endtask

    task automatic settle();
        while (actions_q.size() != 0 || readouts_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic spin(input bit up, input int steps, input int pace);
        repeat (steps)
        begin
            wheel_pos = up ? wheel_pos + 2'd1 : wheel_pos - 2'd1;
            clock_ms += $urandom_range(0, pace);
            push_action(ACT_SAMPLE, gray_code(wheel_pos), clock_ms, $urandom);
        end
    endtask

    // mostly clean rotation bursts, with reads, loads and noise mixed in
    task automatic random_phase(input int n);
        int start;
        int r;
        int pick;
        logic [31:0] ld;
        start = queued_total;
        while (queued_total - start < n)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
            begin
                pick = $urandom_range(0, 9);
                spin(1'($urandom_range(0, 1)), $urandom_range(1, 12),
                     (pick < 6) ? 6 : (pick < 9) ? 60 : 400);
            end
            else if (r < 72)
                push_action(ACT_READ, 2'($urandom), $urandom, $urandom);
            else if (r < 82)
            begin
                wheel_pos = 2'($urandom);
                clock_ms += $urandom_range(0, 50);
                push_action(ACT_SAMPLE, gray_code(wheel_pos), clock_ms, $urandom);
            end
            else if (r < 88)
            begin
                ld = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 200 << 16) - (100 << 16);
                push_action(ACT_LOAD, 2'($urandom), $urandom, ld);
            end
            else if (r < 91)
                push_action(ACT_NONE, 2'($urandom), $urandom, $urandom);
            else if (r < 93)
                clock_ms = $urandom;
            else
                push_action(ACT_READ, 2'b00, clock_ms, 32'd0);
        end
        settle();
    endtask

    initial
    begin
        logic [31:0] incr;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // disabled block, reset defaults, load extremes, unused action
        write_reg(REG_ENABLE, 32'd0);
        write_reg(REG_UNUSED, 32'd0);
        push_action(ACT_SAMPLE, 2'b10, 32'd0, 32'd0);
        push_action(ACT_READ, 2'b00, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_action(ACT_NONE, 2'b11, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
        push_action(ACT_LOAD, 2'b00, 32'd0, 32'h8000_0000);
        push_action(ACT_LOAD, 2'b00, 32'd0, 32'h7FFF_FFFF);
        push_action(ACT_READ, 2'b00, 32'd0, 32'd0);
        push_action(ACT_LOAD, 2'b00, 32'd0, 32'd0);
        settle();

        // acceleration, clamp at max, held step, clamp at min, bad transition, slow step
        configure(8'd1, 8'd1, 16'hFFFF, 32'h0001_0000, 32'd0, 32'd100 << 16);
        push_action(ACT_SAMPLE, 2'b10, 32'd1000, 32'd0);
        push_action(ACT_SAMPLE, 2'b11, 32'd1002, 32'd0);
        push_action(ACT_SAMPLE, 2'b01, 32'd1003, 32'd0);
        push_action(ACT_READ, 2'b00, 32'd1003, 32'd0);
        push_action(ACT_SAMPLE, 2'b00, 32'd1005, 32'd0);
        push_action(ACT_READ, 2'b00, 32'd1005, 32'd0);
        push_action(ACT_SAMPLE, 2'b01, 32'd1006, 32'd0);
        push_action(ACT_SAMPLE, 2'b11, 32'd1010, 32'd0);
        push_action(ACT_READ, 2'b00, 32'd1010, 32'd0);
        push_action(ACT_SAMPLE, 2'b00, 32'd1011, 32'd0);
        push_action(ACT_SAMPLE, 2'b10, 32'd1500, 32'd0);
        push_action(ACT_SAMPLE, 2'b11, 32'd1800, 32'd0);
        push_action(ACT_READ, 2'b00, 32'd1800, 32'd0);
        push_action(ACT_LOAD, 2'b00, 32'd1800, 32'hFFFB_0000);
        push_action(ACT_READ, 2'b00, 32'd1800, 32'd0);
        settle();
        wheel_pos = 2'd2;
        clock_ms = 32'd2000;

        configure(8'd4, 8'd1, 16'd200, 32'h0001_0000, -(32'd100 << 16), 32'd100 << 16);
        hold_go = 1'b1;
        random_phase(PHASE_ITEMS);

        // elapsed time wraps early in this phase; read product saturates
        configure(8'd1, 8'd1, 16'hFFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        clock_ms = 32'hFFFF_FF80;
        random_phase(PHASE_ITEMS);

        configure(8'd255, 8'd255, 16'd1, 32'h8000_0000, -(32'd1000 << 16), 32'd1000 << 16);
        random_phase(PHASE_ITEMS);

        // zero divisors, weakest active coefficient, swapped range
        configure(8'd0, 8'd0, 16'd2, 32'd1, 32'd5 << 16, -(32'd5 << 16));
        random_phase(PHASE_ITEMS);

        incr = $urandom_range(1, 1 << 18);
        if ($urandom_range(0, 1))
            incr = -incr;
        configure(8'($urandom_range(1, 8)), 8'($urandom_range(1, 4)),
                  16'($urandom_range(2, 1000)), incr,
                  -$urandom_range(0, 1 << 24), $urandom_range(0, 1 << 24));
        quiet = 1'b1;
        random_phase(PHASE_ITEMS);

        while (readouts_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/qea_pkg.sv
src/quadrature_encoder_with_accel.sv
tb/sv/tb_quadrature_encoder_with_accel.sv
